// ----- rtl/core/debounced_button_command_counter_top_assert.svh -----
// Assertion macros for the debounced button command counter checks
`ifndef DEBOUNCED_BUTTON_COMMAND_COUNTER_TOP_ASSERT_SVH
`define DEBOUNCED_BUTTON_COMMAND_COUNTER_TOP_ASSERT_SVH

// Check a property that is ignored while reset is high
`define DBC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define DBC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/dbc_pkg.sv -----
// Shared types and constants for the debounced button command counter
package dbc_pkg;

  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned IN_TIME_W   = 32;
  localparam int unsigned COUNT_OUT_W = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HOLD     = 2'd1;

  localparam logic [CFG_DATA_W-1:0] DEBOUNCE_RESET = 16'd20;
  localparam logic [CFG_DATA_W-1:0] HOLD_RESET     = 16'd1000;

  localparam logic [1:0] EDGE_NONE = 2'd0;
  localparam logic [1:0] EDGE_RISE = 2'd1;
  localparam logic [1:0] EDGE_FALL = 2'd2;

  typedef struct packed {
    logic                 sample_level;
    logic [IN_TIME_W-1:0] now_ms;
  } dbc_in_t;

  typedef struct packed {
    logic                   level_out;
    logic [1:0]             edge_out;
    logic                   mode_out;
    logic                   start_event;
    logic                   finish_event;
    logic [COUNT_OUT_W-1:0] count_out;
  } dbc_out_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] debounce_ms;
    logic [CFG_DATA_W-1:0] hold_timeout_ms;
  } dbc_cfg_t;

endpackage

// ----- rtl/core/dbc_chan_if.sv -----
// Valid/ready channel carrying one request payload
interface dbc_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/core/dbc_cfg_regs.sv -----
// Configuration registers for debounce and hold timeout
module dbc_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [dbc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dbc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output dbc_pkg::dbc_cfg_t              cfg
);
  import dbc_pkg::*;

  dbc_cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.debounce_ms     <= DEBOUNCE_RESET;
      regs.hold_timeout_ms <= HOLD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEBOUNCE: regs.debounce_ms     <= cfg_wdata;
        REG_HOLD:     regs.hold_timeout_ms <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = regs;
endmodule

// ----- rtl/core/dbc_in_stage.sv -----
// Input register stage: captures one sample request per cycle unless the next stage stalls it
module dbc_in_stage (
  input logic       clk,
  input logic       rst,
  dbc_chan_if.sink   in_chan,
  dbc_chan_if.source mid_chan
);
  import dbc_pkg::*;

  logic    held_valid;
  dbc_in_t held_req;

  // take a new request whenever the stage is empty or the held one moves on this cycle
  assign in_chan.ready = !held_valid || mid_chan.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_chan.ready) begin
      held_valid <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      held_req <= in_chan.payload;
    end
  end

  assign mid_chan.valid   = held_valid;
  assign mid_chan.payload = held_req;
endmodule

// ----- rtl/core/dbc_core.sv -----
// Debounce, edge detect and command mode update with result register
module dbc_core #(
  parameter int unsigned TIME_WIDTH  = 32,
  parameter int unsigned COUNT_WIDTH = 8
) (
  input logic              clk,
  input logic              rst,
  input dbc_pkg::dbc_cfg_t cfg,
  dbc_chan_if.sink          mid_chan,
  dbc_chan_if.source        out_chan
);
  import dbc_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  // state
  logic                   stable_level;
  logic [TIME_WIDTH-1:0]  last_agree_time;
  logic [TIME_WIDTH-1:0]  edge_time;
  logic                   command_mode;
  logic [COUNT_WIDTH-1:0] press_count;

  logic                   stable_level_next;
  logic [TIME_WIDTH-1:0]  last_agree_time_next;
  logic [TIME_WIDTH-1:0]  edge_time_next;
  logic                   command_mode_next;
  logic [COUNT_WIDTH-1:0] press_count_next;
  logic [1:0]             edge_kind;

  logic                  res_valid;
  dbc_out_t              res;
  dbc_out_t              res_next;
  logic                  advance;
  logic [TIME_WIDTH-1:0] now;
  logic [TIME_WIDTH-1:0] agree_elapsed;
  logic [TIME_WIDTH-1:0] edge_elapsed;
  logic                  level;
  logic                  held_long;
  logic                  start;
  logic                  finish;

  assign mid_chan.ready = !res_valid || out_chan.ready;
  assign advance        = mid_chan.valid && mid_chan.ready;

  assign level         = mid_chan.payload.sample_level;
  assign now           = TIME_WIDTH'(mid_chan.payload.now_ms);
  assign agree_elapsed = now - last_agree_time;

  always_comb begin
    stable_level_next    = stable_level;
    last_agree_time_next = last_agree_time;
    edge_time_next       = edge_time;
    edge_kind            = EDGE_NONE;
    if (level == stable_level) begin
      last_agree_time_next = now;
    end else if (agree_elapsed >= TIME_WIDTH'(cfg.debounce_ms)) begin
      stable_level_next = level;
      edge_time_next    = now;
      edge_kind         = level ? EDGE_RISE : EDGE_FALL;
    end
  end

  assign edge_elapsed = now - edge_time_next;
  assign held_long    = edge_elapsed > TIME_WIDTH'(cfg.hold_timeout_ms);

  always_comb begin
    command_mode_next = command_mode;
    press_count_next  = press_count;
    start             = 1'b0;
    finish            = 1'b0;
    if (!command_mode) begin
      if (stable_level_next && held_long) begin
        command_mode_next = 1'b1;
        press_count_next  = '0;
        start             = 1'b1;
      end
    end else if (!stable_level_next && held_long) begin
      command_mode_next = 1'b0;
      finish            = 1'b1;
    end else if (edge_kind == EDGE_RISE && press_count != COUNT_MAX) begin
      press_count_next = press_count + 1'b1;
    end
  end

  always_comb begin
    res_next.level_out    = stable_level_next;
    res_next.edge_out     = edge_kind;
    res_next.mode_out     = command_mode;
    res_next.start_event  = start;
    res_next.finish_event = finish;
    res_next.count_out    = COUNT_OUT_W'(press_count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stable_level    <= 1'b0;
      last_agree_time <= '0;
      edge_time       <= '0;
      command_mode    <= 1'b0;
      press_count     <= '0;
      res_valid       <= 1'b0;
    end else begin
      if (advance) begin
        stable_level    <= stable_level_next;
        last_agree_time <= last_agree_time_next;
        edge_time       <= edge_time_next;
        command_mode    <= command_mode_next;
        press_count     <= press_count_next;
      end
      if (mid_chan.ready) begin
        res_valid <= mid_chan.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign out_chan.valid   = res_valid;
  assign out_chan.payload = res;
endmodule

// ----- rtl/core/debounced_button_command_counter_top.sv -----
// Top level of the debounced button command counter
//
//   channel   dir  handshake      payload
//   in_chan   in   valid/ready    sample_level, now_ms
//   out_chan  out  valid/ready    level_out, edge_out, mode_out, start/finish, count
//   cfg       in   cfg_we         cfg_index, cfg_wdata (no read-back)
//
// One sample per clock while out_chan is not stalled; a result is offered once its request has
// passed the input register and then the result register behind one pass of compare logic.
// Synchronous active-high reset clears state and both valid flags; no clearing pass.
// A stalled result holds while the input register takes at most one more request, if empty.
module debounced_button_command_counter_top #(
  parameter int unsigned TIME_WIDTH  = 32,
  parameter int unsigned COUNT_WIDTH = 8
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            cfg_we,
  input logic [dbc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input logic [dbc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  dbc_chan_if.sink                       in_chan,
  dbc_chan_if.source                     out_chan
);
  import dbc_pkg::*;

  dbc_cfg_t cfg;

  dbc_chan_if #(.payload_t(dbc_in_t)) mid_chan ();

  dbc_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  dbc_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .in_chan  (in_chan),
    .mid_chan (mid_chan.source)
  );

  dbc_core #(
    .TIME_WIDTH  (TIME_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .mid_chan (mid_chan.sink),
    .out_chan (out_chan)
  );
endmodule

// ----- rtl/core/dbc_checker.sv -----
// Port-level checks for the debounced button command counter
`include "debounced_button_command_counter_top_assert.svh"

module dbc_checker (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input dbc_pkg::dbc_out_t out_res
);
  import dbc_pkg::*;

  // entering command mode only from normal mode, with the count cleared
  `DBC_ASSERT(a_start_clears, clk, rst, (out_valid && out_res.start_event) |-> (!out_res.mode_out && out_res.count_out == '0 && out_res.level_out), "start without clear or from command mode")

  // leaving command mode only from command mode, on a low level
  `DBC_ASSERT(a_finish_low, clk, rst, (out_valid && out_res.finish_event) |-> (out_res.mode_out && !out_res.level_out && !out_res.start_event), "finish outside command mode or on high level")

  // a reported edge matches the debounced level
  `DBC_ASSERT(a_edge_level, clk, rst, out_valid |-> ((out_res.edge_out == EDGE_NONE) || (out_res.edge_out == EDGE_RISE && out_res.level_out) || (out_res.edge_out == EDGE_FALL && !out_res.level_out)), "edge code disagrees with level")

  // hold a stalled result
  `DBC_ASSERT(a_stall_hold, clk, rst, (out_valid && !out_ready) |=> (out_valid && $stable(out_res)), "stalled result changed")

  `DBC_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> !out_valid, "result valid right after reset")
endmodule

bind debounced_button_command_counter_top dbc_checker u_dbc_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_res   (out_chan.payload)
);
